/* design/msp_pkg.sv */
// Package for the multichannel soft PWM block.
// Holds the beat payload types, the command codes and the bank control struct.
// No dependencies.
`default_nettype none

package msp_pkg;

	// Fixed widths of the payload fields.
	localparam int PIN_W   = 10;
	localparam int CHAN_W  = 4;
	localparam int DUTY_W  = 8;
	localparam int COUNT_W = 8;

	// Command codes carried in the command field.
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Input beat: one tick or one pending duty write.
	typedef struct packed {
		logic              command;
		logic [CHAN_W-1:0] channel;
		logic [DUTY_W-1:0] duty;
	} in_t;

	// Output beat: pin levels and the two status flags.
	typedef struct packed {
		logic [PIN_W-1:0] pins;
		logic             period_start;
		logic             write_accepted;
	} out_t;

	// Control from the period counter to the channel bank.
	typedef struct packed {
		logic               tick;
		logic               wrap;
		logic               write;
		logic [CHAN_W-1:0]  chan;
		logic [DUTY_W-1:0]  duty;
		logic [COUNT_W-1:0] count_next;
	} bank_ctrl_t;

endpackage

`default_nettype wire

/* design/msp_chan_bank.sv */
// Channel bank of the multichannel soft PWM: pending and active compares per
// channel and the pin level register. Depends on msp_pkg.
`default_nettype none

module msp_chan_bank #(
	parameter int CHANNELS = 10
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  msp_pkg::bank_ctrl_t       ctrl,
	output logic [msp_pkg::PIN_W-1:0] pins_next
);
	import msp_pkg::*;

	logic [DUTY_W-1:0] pending_q [CHANNELS];
	logic [DUTY_W-1:0] active_q  [CHANNELS];
	logic [PIN_W-1:0]  pins_q;

	// Compare registers: a write updates one pending entry, a wrapping tick
	// copies every pending entry into its active entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pending_q[i] <= '0;
				active_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (ctrl.write && ctrl.chan == CHAN_W'(i)) begin
					pending_q[i] <= ctrl.duty;
				end
				if (ctrl.tick && ctrl.wrap) begin
					active_q[i] <= pending_q[i];
				end
			end
		end
	end

	// Next pin levels: set on wrap, cleared where the active compare meets the count.
	for (genvar g = 0; g < PIN_W; g++) begin : g_pin
		if (g < CHANNELS) begin : g_used
			logic [DUTY_W-1:0] cmp;
			logic              pin_nx;
			assign cmp = ctrl.wrap ? pending_q[g] : active_q[g];
			always_comb begin
				pin_nx = pins_q[g];
				if (ctrl.tick) begin
					if (ctrl.wrap) begin
						pin_nx = 1'b1;
					end
					if (cmp == ctrl.count_next) begin
						pin_nx = 1'b0;
					end
				end
			end
			assign pins_next[g] = pin_nx;
		end else begin : g_unused
			assign pins_next[g] = 1'b0;
		end
	end

	// Pin level register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q <= '0;
		end else if (ctrl.tick) begin
			pins_q <= pins_next;
		end
	end

endmodule

`default_nettype wire

/* design/multichannel_soft_pwm.sv */
// Multichannel soft PWM: top level with the period counter, the period top
// register and the output register. Depends on msp_pkg and msp_chan_bank.
//
// Usage: the in channel carries beats of type in_t. A tick beat advances the
// period counter; when the advanced count reaches period_top the counter wraps
// to zero, all pending compares load into the active compares and every pin
// goes high, then any pin whose active compare equals the count goes low.
// A write beat stores the duty as the pending compare of one channel; a
// channel at or above CHANNELS is ignored. Each input beat yields exactly one
// out beat with the pin levels and the period_start and write_accepted flags.
// The result is registered: it is loaded into the output register when the
// input beat is taken and can be taken by the receiver in the cycle after.
// Throughput is one beat per cycle, set by the single output register:
// in_ready is high whenever that register is empty or is being emptied, so a
// stalled receiver stalls the input side.
// The cfg channel writes period_top and is always ready.
// Reset clears the counter, all compares and the pins, and sets period_top
// to 255.
`default_nettype none

module multichannel_soft_pwm #(
	parameter int CHANNELS = 10
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  msp_pkg::in_t                in_data,
	output logic                        out_valid,
	input  wire                         out_ready,
	output msp_pkg::out_t               out_data,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [msp_pkg::COUNT_W-1:0]  cfg_data
);
	import msp_pkg::*;

	localparam int CH_CNT_W = CHAN_W + 1;

	logic [COUNT_W-1:0] top_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W:0]   count_inc;
	logic               wrap;
	logic               in_fire;
	logic               is_tick;
	logic               is_write;
	logic               chan_ok;
	bank_ctrl_t         ctrl;
	logic [PIN_W-1:0]   pins_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign is_tick   = in_fire && (in_data.command == CMD_TICK);
	assign is_write  = in_fire && (in_data.command == CMD_WRITE);
	assign chan_ok   = {1'b0, in_data.channel} < CH_CNT_W'(CHANNELS);

	// Period counter advance and wrap detection.
	assign count_inc = {1'b0, count_q} + 1'b1;
	assign wrap      = count_inc >= {1'b0, top_q};

	always_comb begin
		ctrl.tick       = is_tick;
		ctrl.wrap       = wrap;
		ctrl.write      = is_write && chan_ok;
		ctrl.chan       = in_data.channel;
		ctrl.duty       = in_data.duty;
		ctrl.count_next = wrap ? '0 : count_inc[COUNT_W-1:0];
	end

	msp_chan_bank #(
		.CHANNELS(CHANNELS)
	) u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.pins_next(pins_next)
	);

	// Period top register and period counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '1;
			count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				top_q <= cfg_data;
			end
			if (is_tick) begin
				count_q <= ctrl.count_next;
			end
		end
	end

	// Output register: loads on every accepted beat, empties when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data.pins           <= pins_next;
			out_data.period_start   <= is_tick && wrap;
			out_data.write_accepted <= is_write && chan_ok;
		end
	end

	// A beat never reports both a period start and a write.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.period_start && out_data.write_accepted))
		else $error("period_start and write_accepted both set");

	// A wrapping tick leaves the counter at zero and flags the period start.
	a_wrap_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && wrap) |=> (count_q == '0) && out_data.period_start)
		else $error("counter not cleared after wrap");

	// A write beat never reports a period start and leaves the counter alone.
	a_write_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		is_write |=> !out_data.period_start && $stable(count_q))
		else $error("write beat disturbed the period counter");

endmodule

`default_nettype wire
